[src/plist_pkg.sv]
package plist_pkg;

    localparam int OPCODE_W = 3;
    localparam int POS_W    = 6;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    typedef logic [OPCODE_W-1:0] opcode_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [DATA_W-1:0]   word_t;

    // operation codes
    localparam opcode_t OP_APPEND   = 3'd0;
    localparam opcode_t OP_INSERT   = 3'd1;
    localparam opcode_t OP_POP_LAST = 3'd2;
    localparam opcode_t OP_POP_AT   = 3'd3;
    localparam opcode_t OP_READ     = 3'd4;
    localparam opcode_t OP_SIZE     = 3'd5;
    localparam opcode_t OP_CLEAR    = 3'd6;
    localparam opcode_t OP_SORT     = 3'd7;

    // status codes
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_RANGE = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;
    localparam status_t ST_FULL  = 2'd3;

endpackage

[src/positional_list_engine_with_sort_unit.sv]
// Append, size, clear and every refused request go straight to the done state; read and remove
// last first wait for one memory read; insert at p shifts the entries from p upward, remove at p
// shifts the entries after p downward, and sort runs an insertion sort over the list. The engine
// takes one transaction at a time, set by the single read and write port of the list memory that
// every shift and sort step walks; a result waits in the response register while the next
// transaction is taken. Reset clears the entry count and control state only.
module positional_list_engine_with_sort_unit #(
    parameter int DEPTH = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_valid,
    output logic                                 cmd_stall,
    input  logic        [plist_pkg::OPCODE_W-1:0] opcode,
    input  logic        [plist_pkg::POS_W-1:0]    position,
    input  logic signed [plist_pkg::DATA_W-1:0]   value,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output logic signed [plist_pkg::DATA_W-1:0]   data,
    output logic        [plist_pkg::COUNT_W-1:0]  count,
    output logic        [plist_pkg::STATUS_W-1:0] status
);

    import plist_pkg::*;

    // CW holds 0..DEPTH, AW addresses the memory, PW is wide enough to compare
    // a position against the entry count without losing bits.
    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_WR,   // shift entries up by one, one per cycle, from the end down
        S_INS_PUT,  // drop the new value into the freed slot
        S_POP_WAIT, // collect the last entry
        S_AT_WAIT,  // collect the addressed entry
        S_DEL_WR,   // shift entries down by one, one per cycle
        S_SK_WAIT,  // sort: collect the key
        S_SCMP,     // sort: compare key with left neighbour, shift or settle
        S_SPUT,     // sort: key reached the head of the list
        S_DONE      // hand the result to the response register
    } state_t;

    // List memory: one write port and one registered read port.
    word_t             store_reg [DEPTH];
    word_t             rd_data_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    word_t             mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    state_t            state_reg,      state_next;
    logic [CW-1:0]     ent_cnt_reg,    ent_cnt_next;
    logic [CW-1:0]     idx_reg,        idx_next;
    logic [CW-1:0]     pos_reg,        pos_next;
    logic [CW-1:0]     j_reg,          j_next;
    word_t             val_reg,        val_next;
    word_t             key_reg,        key_next;
    opcode_t           op_reg,         op_next;
    word_t             res_data_reg,   res_data_next;
    status_t           res_status_reg, res_status_next;
    logic              rsp_valid_reg,  rsp_valid_next;
    word_t             data_reg,       data_next;
    logic [COUNT_W-1:0] count_reg,     count_next;
    status_t           status_reg,     status_next;

    logic [CW-1:0]     cnt_inc;
    logic [CW-1:0]     cnt_dec;
    logic [CW-1:0]     idx_inc;
    logic [CW-1:0]     idx_inc2;
    logic [CW-1:0]     idx_dec;
    logic [CW-1:0]     idx_dec2;
    logic [CW-1:0]     j_dec;
    logic [CW-1:0]     j_dec2;
    logic [CW-1:0]     pos_inc;
    logic [CW-1:0]     pos_ext;
    logic [PW-1:0]     pos_wide;
    logic [PW-1:0]     cnt_wide;
    logic              is_full;
    logic              is_empty;
    logic              pos_past_end;
    logic              key_less;

    assign cnt_inc      = ent_cnt_reg + CW'(1);
    assign cnt_dec      = ent_cnt_reg - CW'(1);
    assign idx_inc      = idx_reg + CW'(1);
    assign idx_inc2     = idx_reg + CW'(2);
    assign idx_dec      = idx_reg - CW'(1);
    assign idx_dec2     = idx_reg - CW'(2);
    assign j_dec        = j_reg - CW'(1);
    assign j_dec2       = j_reg - CW'(2);
    assign pos_inc      = pos_reg + CW'(1);
    assign pos_ext      = CW'(position);
    assign pos_wide     = PW'(position);
    assign cnt_wide     = PW'(ent_cnt_reg);
    assign is_full      = (ent_cnt_reg == CW'(DEPTH));
    assign is_empty     = (ent_cnt_reg == '0);
    assign pos_past_end = (pos_wide >= cnt_wide);
    assign key_less     = ($signed(key_reg) < $signed(rd_data_reg));

    // A read never addresses the entry written in the same cycle, and the
    // entry read always lies outside the part already rewritten, so the walk
    // needs no forwarding.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_reg[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= store_reg[mem_raddr];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        ent_cnt_next    = ent_cnt_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        j_next          = j_reg;
        val_next        = val_reg;
        key_next        = key_reg;
        op_next         = op_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg & rsp_stall;
        data_next       = data_reg;
        count_next      = count_reg;
        status_next     = status_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    res_data_next   = '0;
                    res_status_next = ST_OK;
                    op_next         = opcode;
                    state_next      = S_DONE;
                    case (opcode)
                        OP_APPEND, OP_INSERT:
                        begin
                            if (is_full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else if (opcode == OP_APPEND || pos_past_end)
                            begin
                                // write straight to the tail
                                mem_we       = 1'b1;
                                mem_waddr    = ent_cnt_reg[AW-1:0];
                                mem_wdata    = value;
                                ent_cnt_next = cnt_inc;
                            end
                            else
                            begin
                                idx_next   = ent_cnt_reg;
                                pos_next   = pos_ext;
                                val_next   = value;
                                mem_re     = 1'b1;
                                mem_raddr  = cnt_dec[AW-1:0];
                                state_next = S_INS_WR;
                            end
                        end
                        OP_POP_LAST:
                        begin
                            if (is_empty)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mem_re       = 1'b1;
                                mem_raddr    = cnt_dec[AW-1:0];
                                ent_cnt_next = cnt_dec;
                                state_next   = S_POP_WAIT;
                            end
                        end
                        OP_POP_AT, OP_READ:
                        begin
                            if (is_empty)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else if (pos_past_end)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else
                            begin
                                pos_next   = pos_ext;
                                mem_re     = 1'b1;
                                mem_raddr  = pos_ext[AW-1:0];
                                state_next = S_AT_WAIT;
                            end
                        end
                        OP_SIZE:
                        begin
                            if (is_empty)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                        end
                        OP_CLEAR:
                        begin
                            ent_cnt_next = '0;
                        end
                        OP_SORT:
                        begin
                            if (is_empty)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else if (ent_cnt_reg > CW'(1))
                            begin
                                idx_next   = CW'(1);
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(1);
                                state_next = S_SK_WAIT;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_INS_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[AW-1:0];
                mem_wdata = rd_data_reg;
                idx_next  = idx_dec;
                if (idx_dec == pos_reg)
                begin
                    state_next = S_INS_PUT;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_dec2[AW-1:0];
                end
            end

            S_INS_PUT:
            begin
                mem_we       = 1'b1;
                mem_waddr    = pos_reg[AW-1:0];
                mem_wdata    = val_reg;
                ent_cnt_next = cnt_inc;
                state_next   = S_DONE;
            end

            S_POP_WAIT:
            begin
                res_data_next = rd_data_reg;
                state_next    = S_DONE;
            end

            S_AT_WAIT:
            begin
                res_data_next = rd_data_reg;
                if (op_reg == OP_READ)
                begin
                    state_next = S_DONE;
                end
                else if (pos_inc < ent_cnt_reg)
                begin
                    idx_next   = pos_reg;
                    mem_re     = 1'b1;
                    mem_raddr  = pos_inc[AW-1:0];
                    state_next = S_DEL_WR;
                end
                else
                begin
                    ent_cnt_next = cnt_dec;
                    state_next   = S_DONE;
                end
            end

            S_DEL_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[AW-1:0];
                mem_wdata = rd_data_reg;
                idx_next  = idx_inc;
                if (idx_inc2 < ent_cnt_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_inc2[AW-1:0];
                end
                else
                begin
                    ent_cnt_next = cnt_dec;
                    state_next   = S_DONE;
                end
            end

            S_SK_WAIT:
            begin
                key_next   = rd_data_reg;
                j_next     = idx_reg;
                mem_re     = 1'b1;
                mem_raddr  = idx_dec[AW-1:0];
                state_next = S_SCMP;
            end

            S_SCMP:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg[AW-1:0];
                if (key_less)
                begin
                    // move the larger neighbour right and keep walking left
                    mem_wdata = rd_data_reg;
                    j_next    = j_dec;
                    if (j_dec == '0)
                    begin
                        state_next = S_SPUT;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = j_dec2[AW-1:0];
                    end
                end
                else
                begin
                    // settle the key and fetch the next one
                    mem_wdata = key_reg;
                    idx_next  = idx_inc;
                    if (idx_inc < ent_cnt_reg)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = idx_inc[AW-1:0];
                        state_next = S_SK_WAIT;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_SPUT:
            begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = key_reg;
                idx_next  = idx_inc;
                if (idx_inc < ent_cnt_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_inc[AW-1:0];
                    state_next = S_SK_WAIT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // hold here until the response register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    data_next      = res_data_reg;
                    count_next     = COUNT_W'(ent_cnt_reg);
                    status_next    = res_status_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ent_cnt_reg    <= '0;
            idx_reg        <= '0;
            pos_reg        <= '0;
            j_reg          <= '0;
            val_reg        <= '0;
            key_reg        <= '0;
            op_reg         <= OP_APPEND;
            res_data_reg   <= '0;
            res_status_reg <= ST_OK;
            rsp_valid_reg  <= 1'b0;
            data_reg       <= '0;
            count_reg      <= '0;
            status_reg     <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            ent_cnt_reg    <= ent_cnt_next;
            idx_reg        <= idx_next;
            pos_reg        <= pos_next;
            j_reg          <= j_next;
            val_reg        <= val_next;
            key_reg        <= key_next;
            op_reg         <= op_next;
            res_data_reg   <= res_data_next;
            res_status_reg <= res_status_next;
            rsp_valid_reg  <= rsp_valid_next;
            data_reg       <= data_next;
            count_reg      <= count_next;
            status_reg     <= status_next;
        end
    end

    // Take a new transaction only between operations; the response register
    // parts the two channels.
    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign data      = data_reg;
    assign count     = count_reg;
    assign status    = status_reg;

endmodule

[tb/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import plist_pkg::*;

    // Size of the list held by the engine under test.
    localparam int LIST_DEPTH   = 64;
    // Stimulus volume: at least 1030 transactions in all, directed opening included.
    localparam int TOTAL_ITEMS  = 1030;
    // The closing stretch of the run goes with no idling on either side.
    localparam int QUIET_ITEMS  = 150;
    // A full-list sort is the slowest transaction; the limit allows several times its length,
    // plus the longest stall and gap, before giving up.
    localparam int STALL_LIMIT  = 20000;
    // Settling time after the last owed result: covers the slowest transaction.
    localparam int SETTLE_CYCLES = 2500;

    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [COUNT_W-1:0] cnt_t;

    // What the engine should answer for one transaction.
    typedef struct {
        opcode_t op;
        word_t   data;
        cnt_t    count;
        status_t status;
    } outcome_t;

    // One queued command, with its predicted answer and the sender's behaviour after it.
    typedef struct {
        opcode_t  op;
        pos_t     pos;
        word_t    val;
        outcome_t want;
        int       gap;
        bit       drain_first;
        bit       tail;
    } command_t;

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    cmd_valid = 1'b0;
    logic    cmd_stall;
    opcode_t opcode    = OP_APPEND;
    pos_t    position  = '0;
    word_t   value     = '0;
    logic    rsp_valid;
    logic    rsp_stall = 1'b0;
    word_t   data;
    cnt_t    count;
    status_t status;

    // Commands waiting to be sent, and answers owed by the engine for sent ones.
    command_t pending_cmds[$];
    outcome_t owed_results[$];

    // Shadow copy of the list, advanced as commands are generated.
    word_t list_model [LIST_DEPTH];
    int    list_len = 0;

    // Generation controls.
    int    gen_idle_pct = 0;
    bit    drain_next   = 1'b0;

    int    errors      = 0;
    bit    quiet_phase = 1'b0;

    positional_list_engine_with_sort_unit #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .opcode   (opcode),
        .position (position),
        .value    (value),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .data     (data),
        .count    (count),
        .status   (status)
    );

    initial forever #1 clk = ~clk;

    // ------------------------------------------------------------------
    // List behaviour: apply one command to the shadow list and give back
    // the answer the engine owes for it.
    // ------------------------------------------------------------------
    function automatic outcome_t apply_command(opcode_t op, pos_t pos, word_t val);
        outcome_t r;
        int       slot;
        int       i;
        int       j;
        word_t    key;
        r.op     = op;
        r.data   = '0;
        r.status = ST_OK;
        case (op)
            OP_APPEND, OP_INSERT:
            begin
                // A full list refuses both append and insert.
                if (list_len >= LIST_DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    // Insert at or past the end appends, empty list included.
                    slot = (op == OP_APPEND || int'(pos) >= list_len) ? list_len : int'(pos);
                    for (i = list_len; i > slot; i--)
                        list_model[i] = list_model[i-1];
                    list_model[slot] = val;
                    list_len++;
                end
            end
            OP_POP_LAST:
            begin
                if (list_len == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    list_len--;
                    r.data = list_model[list_len];
                end
            end
            OP_POP_AT, OP_READ:
            begin
                if (list_len == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else if (int'(pos) >= list_len)
                begin
                    r.status = ST_RANGE;
                end
                else
                begin
                    r.data = list_model[pos];
                    if (op == OP_POP_AT)
                    begin
                        for (i = int'(pos); i + 1 < list_len; i++)
                            list_model[i] = list_model[i+1];
                        list_len--;
                    end
                end
            end
            OP_SIZE:
            begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
            end
            OP_CLEAR:
            begin
                list_len = 0;
            end
            default:
            begin
                // Sort ascending, signed order, stable insertion sort.
                if (list_len == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    for (i = 1; i < list_len; i++)
                    begin
                        key = list_model[i];
                        j   = i;
                        while (j > 0 && $signed(key) < $signed(list_model[j-1]))
                        begin
                            list_model[j] = list_model[j-1];
                            j--;
                        end
                        list_model[j] = key;
                    end
                end
            end
        endcase
        r.count = cnt_t'(list_len);
        return r;
    endfunction

    // Queue a command, predicting its answer as it goes in.
    task automatic add_command(opcode_t op, pos_t pos, word_t val);
        command_t c;
        c.op          = op;
        c.pos         = pos;
        c.val         = val;
        c.want        = apply_command(op, pos, val);
        c.tail        = (pending_cmds.size() >= TOTAL_ITEMS - QUIET_ITEMS);
        c.gap         = (!c.tail && int'($urandom_range(0, 99)) < gen_idle_pct)
                        ? int'($urandom_range(1, 13)) : 0;
        c.drain_first = drain_next && !c.tail;
        drain_next    = 1'b0;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    // Mostly a position inside the list, sometimes the end, sometimes anywhere.
    function automatic pos_t pick_pos();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7 && list_len > 0)
            return pos_t'($urandom_range(0, list_len - 1));
        else if (r < 8)
            return pos_t'((list_len > 63) ? 63 : list_len);
        else
            return pos_t'($urandom_range(0, 63));
    endfunction

    // Extremes, small values that collide often, and full-range noise.
    function automatic word_t pick_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4, 5:    return word_t'(int'($urandom_range(0, 16)) - 8);
            default: return word_t'($urandom());
        endcase
    endfunction

    function automatic opcode_t pick_growth_op();
        return ($urandom_range(0, 1) != 0) ? OP_APPEND : OP_INSERT;
    endfunction

    // Weighted random operation for the mixed sequences; clear kept rare so the list grows.
    function automatic opcode_t pick_mixed_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)      return OP_APPEND;
        else if (r < 45) return OP_INSERT;
        else if (r < 55) return OP_POP_LAST;
        else if (r < 67) return OP_POP_AT;
        else if (r < 85) return OP_READ;
        else if (r < 90) return OP_SIZE;
        else if (r < 92) return OP_CLEAR;
        else             return OP_SORT;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus: fill the command queue up front, then hold reset, then
    // wait for the traffic to finish and give the verdict.
    // ------------------------------------------------------------------
    initial
    begin
        int r;
        int n;

        // Directed opening: every operation but append on an empty list first.
        gen_idle_pct = 20;
        add_command(OP_SIZE,     6'd0,  32'd0);
        add_command(OP_POP_LAST, 6'd0,  32'd0);
        add_command(OP_POP_AT,   6'd0,  32'd0);
        add_command(OP_READ,     6'd0,  32'd0);
        add_command(OP_SORT,     6'd0,  32'd0);
        add_command(OP_CLEAR,    6'd0,  32'd0);
        // Insert into an empty list appends, whatever the position.
        add_command(OP_INSERT,   6'd5,  32'h8000_0000);
        add_command(OP_APPEND,   6'd63, 32'h7FFF_FFFF);
        add_command(OP_INSERT,   6'd0,  32'h0000_0000);
        // Insert well past the end appends.
        add_command(OP_INSERT,   6'd63, 32'hFFFF_FFFF);
        add_command(OP_READ,     6'd0,  32'd0);
        add_command(OP_READ,     6'd3,  32'd0);
        // Reads at and past the end are out of range.
        add_command(OP_READ,     6'd4,  32'd0);
        add_command(OP_READ,     6'd63, 32'h7FFF_FFFF);
        add_command(OP_SORT,     6'd0,  32'd0);
        add_command(OP_READ,     6'd1,  32'd0);
        add_command(OP_POP_AT,   6'd63, 32'd0);
        add_command(OP_POP_AT,   6'd3,  32'd0);
        add_command(OP_POP_LAST, 6'd0,  32'd0);
        // Remove the head of a two-entry list.
        add_command(OP_POP_AT,   6'd0,  32'd0);
        add_command(OP_READ,     6'd0,  32'd0);
        add_command(OP_SIZE,     6'd0,  32'd0);
        add_command(OP_CLEAR,    6'd0,  32'd0);
        add_command(OP_SIZE,     6'd0,  32'd0);

        // Random part. The first sequence fills the list to the brim and
        // first lets the engine drain completely.
        n = 0;
        while (pending_cmds.size() < TOTAL_ITEMS)
        begin
            // Idling density per sequence: none, light or heavy.
            r = $urandom_range(0, 2);
            gen_idle_pct = (r == 0) ? 0 : ((r == 1) ? 10 : 40);
            if (n == 0 || $urandom_range(0, 5) == 0)
                drain_next = 1'b1;
            r = (n == 0) ? 0 : int'($urandom_range(0, 11));
            n++;
            if (r == 0)
            begin
                // Fill to full, then knock on the full list, then look around.
                while (list_len < LIST_DEPTH)
                    add_command(pick_growth_op(), pick_pos(), pick_value());
                repeat ($urandom_range(1, 3))
                    add_command(pick_growth_op(), pick_pos(), pick_value());
                repeat ($urandom_range(2, 5))
                    add_command(OP_READ, pick_pos(), pick_value());
                if ($urandom_range(0, 1) != 0)
                    add_command(OP_SORT, pick_pos(), pick_value());
                repeat ($urandom_range(1, 4))
                    add_command(OP_READ, pick_pos(), pick_value());
            end
            else if (r == 1)
            begin
                // Empty the list by removals, then one removal too many.
                while (list_len > 0)
                    add_command(($urandom_range(0, 1) != 0) ? OP_POP_LAST : OP_POP_AT,
                                pick_pos(), pick_value());
                add_command(($urandom_range(0, 1) != 0) ? OP_POP_LAST : OP_POP_AT,
                            pick_pos(), pick_value());
            end
            else if (r <= 3)
            begin
                // Add a few entries, sort, then read back.
                repeat ($urandom_range(1, 6))
                    add_command(pick_growth_op(), pick_pos(), pick_value());
                add_command(OP_SORT, pick_pos(), pick_value());
                repeat ($urandom_range(1, 5))
                    add_command(OP_READ, pick_pos(), pick_value());
            end
            else if (r == 4)
            begin
                // Noise: any field, any value.
                repeat (5)
                    add_command(opcode_t'($urandom_range(0, 7)), pos_t'($urandom_range(0, 63)),
                                word_t'($urandom()));
            end
            else
            begin
                repeat ($urandom_range(10, 30))
                    add_command(pick_mixed_op(), pick_pos(), pick_value());
            end
        end

        // Hold reset, then let go.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Settle on the falling edge so the sender's and receiver's updates are complete.
        @(negedge clk);
        while (pending_cmds.size() != 0 || cmd_valid || owed_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender: present queued commands, hold while stalled, idle in bursts.
    // ------------------------------------------------------------------
    command_t on_bus;
    int       send_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            // Transaction taken: its answer is now owed.
            if (cmd_valid && !cmd_stall)
                owed_results.insert(owed_results.size(), on_bus.want);

            // Hold the payload while stalled; otherwise the bus is free.
            if (!cmd_valid || !cmd_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    cmd_valid <= 1'b0;
                end
                else if (pending_cmds.size() == 0)
                begin
                    cmd_valid <= 1'b0;
                end
                else if (pending_cmds[0].drain_first && owed_results.size() != 0)
                begin
                    // Pause until the engine has answered everything.
                    cmd_valid <= 1'b0;
                end
                else
                begin
                    on_bus = pending_cmds.pop_front();
                    cmd_valid <= 1'b1;
                    opcode    <= on_bus.op;
                    position  <= on_bus.pos;
                    value     <= on_bus.val;
                    send_gap = on_bus.gap;
                    if (on_bus.tail)
                        quiet_phase = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: check each answer against the oldest owed one, and stall
    // in bursts whose density is re-rolled periodically.
    // ------------------------------------------------------------------
    int recv_gap   = 0;
    int stall_pct  = 0;
    int recv_cycle = 0;

    task automatic report_mismatch(string msg);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    report_mismatch($sformatf(
                        "answer with no transaction owed: data %0d count %0d status %0d",
                        $signed(data), count, status));
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (data !== want.data)
                        report_mismatch($sformatf("op %0d: data %0d, want %0d",
                                                  want.op, $signed(data), $signed(want.data)));
                    if (count !== want.count)
                        report_mismatch($sformatf("op %0d: count %0d, want %0d",
                                                  want.op, count, want.count));
                    if (status !== want.status)
                        report_mismatch($sformatf("op %0d: status %0d, want %0d",
                                                  want.op, status, want.status));
                end
            end

            // Re-roll the stall density now and then; drop it for the closing stretch.
            recv_cycle++;
            if (recv_cycle % 256 == 0)
                stall_pct = ($urandom_range(0, 2) == 0)
                            ? 0 : (($urandom_range(0, 1) != 0) ? 15 : 50);
            if (recv_gap > 0)
            begin
                recv_gap--;
                rsp_stall <= 1'b1;
            end
            else if (!quiet_phase && int'($urandom_range(0, 99)) < stall_pct)
            begin
                recv_gap = int'($urandom_range(1, 13)) - 1;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if neither channel moves for too long.
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] no transaction for %0d cycles, %0d answers still owed",
                         $realtime, STALL_LIMIT, owed_results.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule

[positional_list_engine_with_sort_unit.f]
src/plist_pkg.sv
src/positional_list_engine_with_sort_unit.sv
tb/testbench.sv
